[rtl/ewm_pkg.sv]
`timescale 1ns / 1ps

package ewm_pkg;

  // Data path sizes.
  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int AVG_W         = 32;
  localparam int INDEX_W       = 16;

  // Configuration register sizes and constants.
  localparam int ALPHA_W     = 17;
  localparam int LIMIT_W     = 16;
  localparam int AGE_W       = LIMIT_W + 1;
  localparam int ALPHA_SHIFT = 16;
  localparam int ALPHA_ONE   = 1 << ALPHA_SHIFT;

  // Register map: byte address is four times the register index.
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ALPHA     = 1'b0;
  localparam logic REG_AGE_LIMIT = 1'b1;

  // Scaled sample width, before it is clamped to the average width.
  localparam int XQ_W   = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int WIDE_W = (XQ_W > AVG_W) ? XQ_W : AVG_W;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_W       = SAMPLE_WIDTH;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = INDEX_W + 3 * SAMPLE_WIDTH + AVG_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Per-item control shared by the tracking units.
  typedef struct packed {
    logic upd;    // an item is being retired this cycle
    logic first;  // it is the first item since reset
  } step_ctl_t;

  // Clamp a wide signed value to the signed average range.
  function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [WIDE_W+3:0] v);
    logic signed [WIDE_W+3:0] hi;
    logic signed [WIDE_W+3:0] lo;
    hi = (WIDE_W+4)'({1'b0, {(AVG_W-1){1'b1}}});
    lo = -hi - (WIDE_W+4)'(1);
    if (v > hi) begin
      sat_avg = hi[AVG_W-1:0];
    end else if (v < lo) begin
      sat_avg = lo[AVG_W-1:0];
    end else begin
      sat_avg = v[AVG_W-1:0];
    end
  endfunction

endpackage

[rtl/ewm_cfg.sv]
`timescale 1ns / 1ps

module ewm_cfg
  import ewm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output logic [ALPHA_W-1:0]    alpha,
  output logic [LIMIT_W-1:0]    age_limit
);

  logic [ALPHA_W-1:0] alpha_r;
  logic [LIMIT_W-1:0] age_limit_r;
  logic               wr_en;
  logic               sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign sel        = cfg_paddr[2];

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_W'(ALPHA_ONE / 2);
      age_limit_r <= LIMIT_W'(16);
    end else if (wr_en) begin
      unique case (sel)
        REG_ALPHA:     alpha_r     <= cfg_pwdata[ALPHA_W-1:0];
        REG_AGE_LIMIT: age_limit_r <= cfg_pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    unique case (sel)
      REG_ALPHA:     cfg_prdata = 32'(alpha_r);
      REG_AGE_LIMIT: cfg_prdata = 32'(age_limit_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign alpha     = alpha_r;
  assign age_limit = age_limit_r;

endmodule

[rtl/ewm_extreme.sv]
`timescale 1ns / 1ps

module ewm_extreme
  import ewm_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  step_ctl_t                      ctl,
  input  logic                           is_max,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic [LIMIT_W-1:0]             age_limit,
  output logic signed [SAMPLE_WIDTH-1:0] mark_nxt
);

  logic signed [SAMPLE_WIDTH-1:0] mark_r;
  logic [AGE_W-1:0]               age_r;
  logic [AGE_W-1:0]               age_nxt;
  logic [AGE_W-1:0]               age_step;
  logic signed [SAMPLE_WIDTH-1:0] mark_step;
  logic                           moved;

  // A strictly better sample moves the mark; otherwise the mark ages.
  always_comb begin
    moved     = is_max ? (x > mark_r) : (x < mark_r);
    mark_step = moved ? x : mark_r;
    age_step  = moved ? age_r : age_r + AGE_W'(1);
    if (ctl.first) begin
      mark_nxt = x;
      age_nxt  = age_r;
    end else if (age_step > {1'b0, age_limit}) begin
      mark_nxt = x;
      age_nxt  = AGE_W'(1);
    end else begin
      mark_nxt = mark_step;
      age_nxt  = age_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
      age_r  <= AGE_W'(1);
    end else if (ctl.upd) begin
      mark_r <= mark_nxt;
      age_r  <= age_nxt;
    end
  end

endmodule

[rtl/ewm_avg.sv]
`timescale 1ns / 1ps

module ewm_avg
  import ewm_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  step_ctl_t                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic [ALPHA_W-1:0]             alpha,
  output logic signed [AVG_W-1:0]        avg_nxt
);

  localparam int DIFF_W = AVG_W + 1;
  localparam int COEF_W = ALPHA_W + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int STEP_W = PROD_W - ALPHA_SHIFT;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(ALPHA_ONE / 2);

  logic signed [AVG_W-1:0]    avg_r;
  logic signed [WIDE_W+3:0]   xq_wide;
  logic signed [AVG_W-1:0]    xq;
  logic [ALPHA_W-1:0]         a_eff;
  logic signed [COEF_W-1:0]   coef;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [STEP_W-1:0]   step;
  logic signed [WIDE_W+3:0]   sum;

  // Scale the sample into the average format, clamped to its range.
  assign xq_wide = (WIDE_W+4)'(x) <<< FRACTION_BITS;
  assign xq      = sat_avg(xq_wide);

  // Weights above one count as exactly one.
  assign a_eff = (alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha;
  assign coef  = {1'b0, a_eff};

  // prev + round(alpha * (xq - prev)), ties toward plus infinity.
  assign diff     = DIFF_W'(xq) - DIFF_W'(avg_r);
  assign prod     = PROD_W'(diff) * PROD_W'(coef);
  assign prod_rnd = prod + RND;
  assign step     = $signed(prod_rnd[PROD_W-1:ALPHA_SHIFT]);
  assign sum      = (WIDE_W+4)'(step) + (WIDE_W+4)'(avg_r);

  assign avg_nxt = ctl.first ? xq : sat_avg(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (ctl.upd) begin
      avg_r <= avg_nxt;
    end
  end

endmodule

[rtl/ewma_with_aged_min_max.sv]
`timescale 1ns / 1ps
// A sample passes through the input register, then the result register, on its
// way to the output. Throughput: one sample per cycle while the output is not
// stalled, set by the average update loop (one multiply and add with the average
// fed back). The result register lets a new sample enter while a finished result
// waits. rst_n is synchronous and clears all statistics, the sample counter and
// the registers to their defaults.

module ewma_with_aged_min_max
  import ewm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample_value
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] sample_number, [31:16] echoed_value, [47:32] running_minimum,
  // [79:48] average, [95:80] running_maximum
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [ALPHA_W-1:0]             alpha;
  logic [LIMIT_W-1:0]             age_limit;

  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r;
  logic                           s1_go;
  logic                           seen_first_r;
  logic [INDEX_W-1:0]             index_r;
  logic [INDEX_W-1:0]             index_nxt;
  step_ctl_t                      ctl;

  logic signed [SAMPLE_WIDTH-1:0] min_nxt;
  logic signed [SAMPLE_WIDTH-1:0] max_nxt;
  logic signed [AVG_W-1:0]        avg_nxt;

  logic                           out_valid_r;
  logic [OUT_TDATA_W-1:0]         out_data_r;

  ewm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .alpha      (alpha),
    .age_limit  (age_limit)
  );

  // The input register moves on when the result register is free or draining.
  assign s1_go     = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready & in_tvalid) begin
      s1_x_r <= in_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  // Sample counter and first-sample flag.
  assign index_nxt = index_r + INDEX_W'(1);
  assign ctl.upd   = s1_go;
  assign ctl.first = ~seen_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r      <= '0;
      seen_first_r <= 1'b0;
    end else if (s1_go) begin
      index_r      <= index_nxt;
      seen_first_r <= 1'b1;
    end
  end

  ewm_extreme u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .is_max   (1'b0),
    .x        (s1_x_r),
    .age_limit(age_limit),
    .mark_nxt (min_nxt)
  );

  ewm_extreme u_max (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .is_max   (1'b1),
    .x        (s1_x_r),
    .age_limit(age_limit),
    .mark_nxt (max_nxt)
  );

  ewm_avg u_avg (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .x      (s1_x_r),
    .alpha  (alpha),
    .avg_nxt(avg_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= OUT_TDATA_W'({max_nxt, avg_nxt, min_nxt, s1_x_r, index_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/ewma_with_aged_min_max_tb.sv]
`timescale 1ns / 1ps

module ewma_with_aged_min_max_tb
  import ewm_pkg::*;
();

  // Cycle budget for the whole run.
  localparam int CYCLE_LIMIT = 100000;

  // One result as it travels on out_tdata, lowest field last.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ceil_val;
    logic signed [AVG_W-1:0]        avg;
    logic signed [SAMPLE_WIDTH-1:0] floor_val;
    logic signed [SAMPLE_WIDTH-1:0] echo;
    logic [INDEX_W-1:0]             seq;
  } stat_rec_t;

  // Kinds of sample runs used by the random stimulus.
  typedef enum int {
    PICK_WIDE,
    PICK_NEAR_ZERO,
    PICK_WALK,
    PICK_HOLD,
    PICK_EDGE
  } sample_pick_e;

  // Tracks the running statistics and holds the results still to arrive.
  class stat_predictor;
    logic [ALPHA_W-1:0]             weight;
    logic [LIMIT_W-1:0]             age_cap;
    logic signed [SAMPLE_WIDTH-1:0] floor_val;
    logic signed [SAMPLE_WIDTH-1:0] ceil_val;
    int                             floor_age;
    int                             ceil_age;
    longint                         avg_q;
    bit                             primed;
    logic [INDEX_W-1:0]             seq_num;
    stat_rec_t                      pending_stats[$];
    int                             errors;

    // Power-on state: alpha one half, age limit sixteen.
    function new();
      weight    = 17'd32768;
      age_cap   = 16'd16;
      floor_val = '0;
      ceil_val  = '0;
      floor_age = 1;
      ceil_age  = 1;
      avg_q     = 0;
      primed    = 1'b0;
      seq_num   = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_ALPHA) begin
        weight = val[ALPHA_W-1:0];
      end else begin
        age_cap = val[LIMIT_W-1:0];
      end
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    // Advance the statistics by one accepted sample and queue its result.
    function void note_input(logic [IN_W-1:0] raw);
      logic signed [SAMPLE_WIDTH-1:0] x;
      longint                         xq;
      longint                         w;
      longint                         prod;
      stat_rec_t                      r;
      x = raw;
      xq = clamp32(longint'(x) <<< FRACTION_BITS);
      seq_num = seq_num + INDEX_W'(1);
      if (!primed) begin
        // The first sample seeds both extremes and the average.
        primed    = 1'b1;
        floor_val = x;
        ceil_val  = x;
        avg_q     = xq;
      end else begin
        w = (longint'(weight) > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(weight);
        if (x < floor_val) begin
          floor_val = x;
        end else begin
          floor_age++;
        end
        if (x > ceil_val) begin
          ceil_val = x;
        end else begin
          ceil_age++;
        end
        // An extreme that has gone unchanged too long restarts here.
        if (floor_age > int'(age_cap)) begin
          floor_val = x;
          floor_age = 1;
        end
        if (ceil_age > int'(age_cap)) begin
          ceil_val = x;
          ceil_age = 1;
        end
        // Round to nearest with ties upward; the shift floors.
        prod  = w * (xq - avg_q);
        avg_q = clamp32(avg_q + ((prod + ALPHA_ONE / 2) >>> ALPHA_SHIFT));
      end
      r.seq       = seq_num;
      r.echo      = x;
      r.floor_val = floor_val;
      r.avg       = avg_q[AVG_W-1:0];
      r.ceil_val  = ceil_val;
      pending_stats.push_back(r);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] data);
      stat_rec_t got;
      stat_rec_t want;
      got = data;
      if (pending_stats.size() == 0) begin
        report("result with nothing pending", data[31:0], 32'h0);
        return;
      end
      want = pending_stats.pop_front();
      if (got.seq !== want.seq) report("sample_number", 32'(got.seq), 32'(want.seq));
      if (got.echo !== want.echo) report("echoed_value", 32'(got.echo), 32'(want.echo));
      if (got.floor_val !== want.floor_val) begin
        report("running_minimum", 32'(got.floor_val), 32'(want.floor_val));
      end
      if (got.avg !== want.avg) report("average", got.avg, want.avg);
      if (got.ceil_val !== want.ceil_val) begin
        report("running_maximum", 32'(got.ceil_val), 32'(want.ceil_val));
      end
    endtask
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;  // [15:0] sample_value
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // [15:0] sample_number, [31:16] echoed_value, [47:32] running_minimum,
  // [79:48] average, [95:80] running_maximum
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [31:0]            cfg_pwdata  = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  stat_predictor          sb;
  bit                     tx_burst    = 1'b0;
  bit                     rx_burst    = 1'b0;
  bit                     steady      = 1'b0;
  int                     rx_wait     = 0;
  int                     sent_total  = 0;
  int                     cycles      = 0;
  sample_pick_e           run_mode    = PICK_WIDE;
  int                     run_left    = 0;
  logic signed [15:0]     last_sample = '0;

  ewma_with_aged_min_max DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: stall a random number of cycles after each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      rx_wait = (rx_burst || steady) ? 0 : $urandom_range(0, 7);
      out_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_tready <= (rx_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Observe every transfer on both streams.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_input(in_tdata[IN_W-1:0]);
    end
  end

  // Runs of samples: wide random, near zero, random walk, repeats and extremes.
  function automatic logic signed [15:0] next_sample();
    logic signed [15:0] v;
    if (run_left == 0) begin
      run_mode = sample_pick_e'($urandom_range(0, 4));
      run_left = $urandom_range(4, 24);
    end
    run_left--;
    case (run_mode)
      PICK_WIDE: begin
        v = 16'($urandom);
      end
      PICK_NEAR_ZERO: begin
        v = 16'($urandom_range(0, 16)) - 16'sd8;
      end
      PICK_WALK: begin
        v = last_sample + 16'($urandom_range(0, 64)) - 16'sd32;
      end
      PICK_HOLD: begin
        v = last_sample;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
    endcase
    last_sample = v;
    return v;
  endfunction

  // Offer one sample after a random gap and hold it until the transfer.
  task automatic send_sample(logic signed [15:0] v);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || steady) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(v);
    do @(posedge clk); while (!in_tready);
    sent_total++;
  endtask

  // Stop sending and wait until every result is in and the pipe is quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write a register, then read it back.
  task automatic cfg_access(logic idx, logic [31:0] val);
    logic [31:0] want;
    want = (idx == REG_ALPHA) ? 32'(val[ALPHA_W-1:0]) : 32'(val[LIMIT_W-1:0]);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) sb.report("register readback", cfg_prdata, want);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] a, logic [31:0] lim);
    drain();
    cfg_access(REG_ALPHA, a);
    cfg_access(REG_AGE_LIMIT, lim);
  endtask

  initial begin
    logic [31:0] a;
    logic [31:0] lim;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: seeding, equal samples, both extremes of the sample range.
    send_sample(16'sd100);
    send_sample(16'sd100);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // Alpha of one follows the sample; age limit zero restarts both extremes.
    set_config(32'd65536, 32'd0);
    send_sample(16'sd5);
    send_sample(-16'sd7);
    send_sample(16'sd5);

    // Alpha zero holds the average; repeated samples age the extremes.
    set_config(32'd0, 32'd2);
    send_sample(16'sd10);
    send_sample(16'sd10);
    send_sample(16'sd10);
    send_sample(16'sd10);
    send_sample(-16'sd3);
    send_sample(16'sd20);

    // Alpha above one is clamped; full-scale swings with the longest age limit.
    set_config(32'd131071, 32'd65535);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          a = 32'd65536;
          lim = 32'd0;
        end
        1: begin
          a = 32'd0;
          lim = 32'd65535;
        end
        2: begin
          a = 32'd131071;
          lim = 32'd1;
        end
        default: begin
          a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                          : $urandom_range(0, 65536);
          lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 24);
        end
      endcase
      set_config(a, lim);
      for (int i = 0; i < 70; i++) begin
        send_sample(next_sample());
      end
    end

    // Back-to-back stretch with no idle cycles on either side.
    set_config($urandom_range(0, 65536), $urandom_range(0, 24));
    steady = 1'b1;
    while (sent_total < 650) begin
      send_sample(next_sample());
    end
    steady = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
